FILE: hw/rtl/topological_sort_stack_top_macros.svh
// ----------------------------------------------------------------------------
// Topological sort assertion macros
// Shared property shapes for the sort block's checks, clocked on clk and
// held off during rst.
// ----------------------------------------------------------------------------
`ifndef TOPOLOGICAL_SORT_STACK_TOP_MACROS_SVH
`define TOPOLOGICAL_SORT_STACK_TOP_MACROS_SVH

// Hold a condition at every clock edge.
`define TSS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Hold a consequence in the same cycle as its antecedent.
`define TSS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// Topological sort package
// Field widths, shared types and parameter defaults of the sort block.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int VERTEX_W         = 6;
  localparam int COUNT_W          = 7;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;

  typedef logic [VERTEX_W-1:0] vertex_t;
  typedef logic [COUNT_W-1:0]  count_t;

endpackage

FILE: hw/rtl/tss_req_if.sv
// ----------------------------------------------------------------------------
// Topological sort request channel
// Carries one edge request per handshake, with the flag that starts a sort.
// ----------------------------------------------------------------------------
interface tss_req_if import tss_pkg::*; ();

  logic    valid;
  logic    ready;
  vertex_t src_vertex;
  vertex_t dst_vertex;
  logic    edge_valid;
  logic    last;

  modport source (
    output valid, src_vertex, dst_vertex, edge_valid, last,
    input  ready
  );

  modport sink (
    input  valid, src_vertex, dst_vertex, edge_valid, last,
    output ready
  );

endinterface

FILE: hw/rtl/tss_rsp_if.sv
// ----------------------------------------------------------------------------
// Topological sort result channel
// Carries one emitted vertex per handshake and the status of the sort.
// ----------------------------------------------------------------------------
interface tss_rsp_if import tss_pkg::*; ();

  logic    valid;
  logic    ready;
  vertex_t vertex;
  logic    vertex_valid;
  logic    last_result;
  logic    all_sorted;
  logic    input_error;

  modport source (
    output valid, vertex, vertex_valid, last_result, all_sorted, input_error,
    input  ready
  );

  modport sink (
    input  valid, vertex, vertex_valid, last_result, all_sorted, input_error,
    output ready
  );

endinterface

FILE: hw/rtl/topological_sort_stack_top.sv
// ----------------------------------------------------------------------------
// Topological sort top level
// Edge loader and stack-based topological sorter over two graph memories.
// ----------------------------------------------------------------------------
// Edge requests load at one per cycle into per-vertex linked edge lists; a
// new edge becomes the head of its source's list. The request flagged last
// starts the sort, and no request is taken until its final result has been
// placed in the output register. The vertex memory and the edge memory
// each have a single read port with a registered read, and every edge
// visit is a read of the edge, a read of its target's in-degree and a write
// back. The ready stack is linked through the vertex memory. No clearing
// pass follows reset.
// ----------------------------------------------------------------------------
`include "topological_sort_stack_top_macros.svh"

module topological_sort_stack_top
  import tss_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_we,
  input  count_t cfg_wdata,
  tss_req_if.sink   req,
  tss_rsp_if.source rsp
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int EC = $clog2(MAX_EDGES + 1);
  localparam int DW = EC;

  localparam count_t       NMAX     = COUNT_W'(MAX_VERTICES);
  localparam logic [EC-1:0] EDGE_CAP = EC'(MAX_EDGES);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_WAIT = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_CV   = 4'd3;
  localparam logic [3:0] S_CH   = 4'd4;
  localparam logic [3:0] S_CE   = 4'd5;
  localparam logic [3:0] S_CR   = 4'd6;
  localparam logic [3:0] S_PR   = 4'd7;
  localparam logic [3:0] S_PC   = 4'd8;
  localparam logic [3:0] S_POP  = 4'd9;
  localparam logic [3:0] S_PD   = 4'd10;
  localparam logic [3:0] S_WE   = 4'd11;
  localparam logic [3:0] S_WR   = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  typedef struct packed {
    logic [EW-1:0] head;
    logic [DW-1:0] indeg;
    logic [VW-1:0] snext;
  } vword_t;

  typedef struct packed {
    logic [VW-1:0] target;
    logic          nvalid;
    logic [EW-1:0] next;
  } eword_t;

  vword_t vmem [MAX_VERTICES];
  eword_t emem [MAX_EDGES];
  vword_t vrd;
  eword_t erd;

  count_t vcount;
  count_t n;

  logic [3:0]        state, state_next;
  count_t            i, i_next;
  logic [VW-1:0]     top, top_next;
  count_t            sd, sd_next;
  count_t            emitted, emitted_next;
  logic [VW-1:0]     pend, pend_next;
  logic              pend_valid, pend_valid_next;

  logic [MAX_VERTICES-1:0] head_valid;
  logic [EC-1:0]     edges_stored;
  logic              dropped;

  logic              p_valid;
  logic [VW-1:0]     p_src;
  logic [VW-1:0]     p_dst;
  logic [EW-1:0]     p_idx;
  logic              fwd;
  logic [EW-1:0]     fwd_idx;

  logic              req_ready;
  logic              acc;
  logic              drop;
  logic              clear_graph;

  logic              v_re;
  logic [VW-1:0]     v_raddr;
  logic [VW-1:0]     v_waddr;
  logic              v_we_head;
  logic              v_we_indeg;
  logic              v_we_snext;
  logic [DW-1:0]     v_indeg_wd;
  logic [VW-1:0]     v_snext_wd;
  logic              e_re;
  logic [EW-1:0]     e_raddr;

  logic              out_free;
  logic              out_load;
  logic              out_valid;
  vertex_t           out_vertex, out_vertex_d;
  logic              out_vvalid, out_vvalid_d;
  logic              out_last, out_last_d;
  logic              out_all, out_all_d;
  logic              out_err, out_err_d;

  assign n        = (vcount > NMAX) ? NMAX : vcount;
  assign acc      = req.valid && req_ready;
  assign drop     = (COUNT_W'(req.src_vertex) >= n) || (COUNT_W'(req.dst_vertex) >= n) ||
                    (edges_stored >= EDGE_CAP);
  assign out_free = !out_valid || rsp.ready;

  assign req.ready        = req_ready;
  assign rsp.valid        = out_valid;
  assign rsp.vertex       = out_vertex;
  assign rsp.vertex_valid = out_vvalid;
  assign rsp.last_result  = out_last;
  assign rsp.all_sorted   = out_all;
  assign rsp.input_error  = out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= COUNT_W'(1);
    end else if (cfg_we) begin
      vcount <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (v_re) begin
      vrd <= vmem[v_raddr];
    end
    if (v_we_head) begin
      vmem[v_waddr].head <= p_idx;
    end
    if (v_we_indeg) begin
      vmem[v_waddr].indeg <= v_indeg_wd;
    end
    if (v_we_snext) begin
      vmem[v_waddr].snext <= v_snext_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (e_re) begin
      erd <= emem[e_raddr];
    end
    if (p_valid) begin
      emem[p_idx] <= '{target: p_dst, nvalid: head_valid[p_src],
                       next: fwd ? fwd_idx : vrd.head};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      edges_stored <= '0;
      dropped      <= 1'b0;
      head_valid   <= '0;
    end else begin
      p_valid <= acc && req.edge_valid && !drop;
      if (p_valid) begin
        head_valid[p_src] <= 1'b1;
      end
      if (acc && req.edge_valid) begin
        if (drop) begin
          dropped <= 1'b1;
        end else begin
          edges_stored <= edges_stored + EC'(1);
        end
      end
      if (clear_graph) begin
        head_valid   <= '0;
        edges_stored <= '0;
        dropped      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_src   <= req.src_vertex[VW-1:0];
      p_dst   <= req.dst_vertex[VW-1:0];
      p_idx   <= edges_stored[EW-1:0];
      fwd     <= p_valid && (p_src == req.src_vertex[VW-1:0]);
      fwd_idx <= p_idx;
    end
  end

  always_comb begin
    state_next      = state;
    i_next          = i;
    top_next        = top;
    sd_next         = sd;
    emitted_next    = emitted;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    req_ready       = 1'b0;
    clear_graph     = 1'b0;
    v_re            = 1'b0;
    v_raddr         = '0;
    v_waddr         = '0;
    v_we_head       = 1'b0;
    v_we_indeg      = 1'b0;
    v_we_snext      = 1'b0;
    v_indeg_wd      = '0;
    v_snext_wd      = '0;
    e_re            = 1'b0;
    e_raddr         = '0;
    out_load        = 1'b0;
    out_vertex_d    = '0;
    out_vvalid_d    = 1'b0;
    out_last_d      = 1'b0;
    out_all_d       = 1'b0;
    out_err_d       = 1'b0;

    if (p_valid) begin
      v_we_head = 1'b1;
      v_waddr   = p_src;
    end

    unique case (state)
      S_LOAD: begin
        req_ready = 1'b1;
        v_re      = acc;
        v_raddr   = req.src_vertex[VW-1:0];
        if (acc && req.last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        i_next       = '0;
        sd_next      = '0;
        emitted_next = '0;
        state_next   = S_CLR;
      end
      S_CLR: begin
        if (i == n) begin
          i_next     = '0;
          state_next = S_CV;
        end else begin
          v_we_indeg = 1'b1;
          v_waddr    = i[VW-1:0];
          i_next     = i + COUNT_W'(1);
        end
      end
      S_CV: begin
        if (i == n) begin
          i_next     = '0;
          state_next = S_PR;
        end else if (head_valid[i[VW-1:0]]) begin
          v_re       = 1'b1;
          v_raddr    = i[VW-1:0];
          state_next = S_CH;
        end else begin
          i_next = i + COUNT_W'(1);
        end
      end
      S_CH: begin
        e_re       = 1'b1;
        e_raddr    = vrd.head;
        state_next = S_CE;
      end
      S_CE: begin
        if (COUNT_W'(erd.target) < n) begin
          v_re       = 1'b1;
          v_raddr    = erd.target;
          state_next = S_CR;
        end else if (erd.nvalid) begin
          e_re    = 1'b1;
          e_raddr = erd.next;
        end else begin
          i_next     = i + COUNT_W'(1);
          state_next = S_CV;
        end
      end
      S_CR: begin
        v_we_indeg = 1'b1;
        v_waddr    = erd.target;
        v_indeg_wd = vrd.indeg + DW'(1);
        if (erd.nvalid) begin
          e_re       = 1'b1;
          e_raddr    = erd.next;
          state_next = S_CE;
        end else begin
          i_next     = i + COUNT_W'(1);
          state_next = S_CV;
        end
      end
      S_PR: begin
        if (i == n) begin
          state_next = S_POP;
        end else begin
          v_re       = 1'b1;
          v_raddr    = i[VW-1:0];
          state_next = S_PC;
        end
      end
      S_PC: begin
        if (vrd.indeg == '0) begin
          v_we_snext = 1'b1;
          v_waddr    = i[VW-1:0];
          v_snext_wd = top;
          top_next   = i[VW-1:0];
          sd_next    = sd + COUNT_W'(1);
        end
        i_next     = i + COUNT_W'(1);
        state_next = S_PR;
      end
      S_POP: begin
        if (sd == '0) begin
          state_next = S_FIN;
        end else begin
          v_re       = 1'b1;
          v_raddr    = top;
          sd_next    = sd - COUNT_W'(1);
          state_next = S_PD;
        end
      end
      S_PD: begin
        if (!pend_valid || out_free) begin
          if (pend_valid) begin
            out_load     = 1'b1;
            out_vertex_d = VERTEX_W'(pend);
            out_vvalid_d = 1'b1;
          end
          pend_next       = top;
          pend_valid_next = 1'b1;
          emitted_next    = emitted + COUNT_W'(1);
          top_next        = vrd.snext;
          if (head_valid[top]) begin
            e_re       = 1'b1;
            e_raddr    = vrd.head;
            state_next = S_WE;
          end else begin
            state_next = S_POP;
          end
        end
      end
      S_WE: begin
        if (COUNT_W'(erd.target) < n) begin
          v_re       = 1'b1;
          v_raddr    = erd.target;
          state_next = S_WR;
        end else if (erd.nvalid) begin
          e_re    = 1'b1;
          e_raddr = erd.next;
        end else begin
          state_next = S_POP;
        end
      end
      S_WR: begin
        if (vrd.indeg != '0) begin
          v_we_indeg = 1'b1;
          v_waddr    = erd.target;
          v_indeg_wd = vrd.indeg - DW'(1);
          if (vrd.indeg == DW'(1)) begin
            v_we_snext = 1'b1;
            v_snext_wd = top;
            top_next   = erd.target;
            sd_next    = sd + COUNT_W'(1);
          end
        end
        if (erd.nvalid) begin
          e_re       = 1'b1;
          e_raddr    = erd.next;
          state_next = S_WE;
        end else begin
          state_next = S_POP;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_vertex_d    = pend_valid ? VERTEX_W'(pend) : '0;
          out_vvalid_d    = pend_valid;
          out_last_d      = 1'b1;
          out_all_d       = (emitted == n);
          out_err_d       = dropped;
          pend_valid_next = 1'b0;
          clear_graph     = 1'b1;
          state_next      = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      i          <= '0;
      sd         <= '0;
      emitted    <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      i          <= i_next;
      sd         <= sd_next;
      emitted    <= emitted_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    top  <= top_next;
    pend <= pend_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vertex <= out_vertex_d;
      out_vvalid <= out_vvalid_d;
      out_last   <= out_last_d;
      out_all    <= out_all_d;
      out_err    <= out_err_d;
    end
  end

  `TSS_ASSERT_ALWAYS(a_stack_bound, sd <= NMAX, "ready stack deeper than vertex capacity")
  `TSS_ASSERT_ALWAYS(a_edge_bound, edges_stored <= EDGE_CAP, "edge pool count above capacity")
  `TSS_ASSERT_IMPLIES(a_load_drained, state == S_CLR, !p_valid, "sort began before edge write")
  `TSS_ASSERT_IMPLIES(a_pend_count, pend_valid, emitted != '0, "pending vertex with no count")

endmodule
